// ===== rtl/ppmr_pkg.sv =====
// ----------------------------------------------------------------------------
// ppmr_pkg
// Types, register codes and arithmetic helpers for the PPM face reconstruction.
// ----------------------------------------------------------------------------
package ppmr_pkg;

	localparam int VAL_W     = 32;
	localparam int CNT_W     = 12;
	localparam int DIFF_W    = 33;
	localparam int SLOPE_W   = 36;
	localparam int FACE_W    = 40;
	localparam int WIDE_W    = 44;
	localparam int UBIAS_W   = 34;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 1;

	typedef logic signed [VAL_W-1:0]   val_t;
	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [SLOPE_W-1:0] slope_t;
	typedef logic signed [FACE_W-1:0]  face_t;
	typedef logic signed [WIDE_W-1:0]  wide_t;
	typedef logic [UBIAS_W-1:0]        ubias_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLOPE_CORR = 1'b0,
		REG_MONO_LIM   = 1'b1
	} reg_idx_t;

	// five-cell window, c0 oldest
	typedef struct packed {
		val_t c0;
		val_t c1;
		val_t c2;
		val_t c3;
		val_t c4;
	} win_t;

	// travels with each stage
	typedef struct packed {
		logic valid;
		cnt_t cell_number;
	} tag_t;

	typedef struct packed {
		logic slope_corr;
		logic mono_lim;
	} cfg_t;

	typedef struct packed {
		logic [15:0] q;
		logic [1:0]  r;
	} div3_t;

	// Doubled theta=2 minmod slope: minmod(4*minmod(a,b), a+b)
	function automatic slope_t slope2(input diff_t a, input diff_t b);
		slope_t ae;
		slope_t be;
		slope_t am;
		slope_t bm;
		slope_t m;
		slope_t c;
		slope_t mm;
		slope_t cm;
		ae = SLOPE_W'(a);
		be = SLOPE_W'(b);
		am = (ae < 0) ? -ae : ae;
		bm = (be < 0) ? -be : be;
		m  = (am < bm) ? ae : be;
		m  = m <<< 2;
		c  = ae + be;
		mm = (m < 0) ? -m : m;
		cm = (c < 0) ? -c : c;
		if (a == '0 || b == '0 || a[DIFF_W-1] != b[DIFF_W-1])
			return '0;
		return (mm < cm) ? m : c;
	endfunction

	// floor(x/3) for x < 3*2^16: reciprocal multiply, then up to two corrections
	function automatic div3_t div3(input logic [17:0] x);
		logic [32:0] prod;
		logic [16:0] q0;
		logic [18:0] r0;
		div3_t       res;
		prod = {15'd0, x} * 33'd21845;
		q0   = prod[32:16];
		r0   = {1'b0, x} - ({2'b00, q0} * 19'd3);
		if (r0 >= 19'd3) begin
			q0 = q0 + 17'd1;
			r0 = r0 - 19'd3;
		end
		if (r0 >= 19'd3) begin
			q0 = q0 + 17'd1;
			r0 = r0 - 19'd3;
		end
		res.q = q0[15:0];
		res.r = r0[1:0];
		return res;
	endfunction

endpackage

// ===== rtl/ppmr_if.sv =====
// ----------------------------------------------------------------------------
// ppmr_if
// Stream channels of the face reconstruction: cells in, face pairs out.
// ----------------------------------------------------------------------------
interface ppmr_cell_if;
	import ppmr_pkg::*;

	logic valid;
	logic ready;
	val_t cell_value;
	logic row_end;

	modport source (output valid, output cell_value, output row_end, input ready);
	modport sink   (input valid, input cell_value, input row_end, output ready);
endinterface

interface ppmr_face_if;
	import ppmr_pkg::*;

	logic valid;
	logic ready;
	cnt_t cell_number;
	val_t left_face;
	val_t right_face;

	modport source (output valid, output cell_number, output left_face, output right_face,
		input ready);
	modport sink   (input valid, input cell_number, input left_face, input right_face,
		output ready);
endinterface

// ===== rtl/ppmr_window.sv =====
// ----------------------------------------------------------------------------
// ppmr_window
// Sample window and row position; registers the five-cell window (stage 1).
// ----------------------------------------------------------------------------
module ppmr_window #(
	parameter int ROW_CELLS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            take,
	input  ppmr_pkg::val_t  cell_value,
	input  logic            row_end,
	output ppmr_pkg::win_t  win_s1,
	output ppmr_pkg::tag_t  tag_s1,
	output ppmr_pkg::cnt_t  row_pos
);
	import ppmr_pkg::*;

	val_t window_q [4];
	cnt_t cnt_q;
	logic last;

	assign last    = row_end || (cnt_q >= CNT_W'(ROW_CELLS - 1));
	assign row_pos = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			tag_s1 <= '0;
			for (int k = 0; k < 4; k++) begin
				window_q[k] <= '0;
			end
		end else begin
			if (en) begin
				tag_s1.valid       <= take && (cnt_q >= CNT_W'(4));
				tag_s1.cell_number <= cnt_q - CNT_W'(2);
			end
			if (take) begin
				window_q[0] <= window_q[1];
				window_q[1] <= window_q[2];
				window_q[2] <= window_q[3];
				window_q[3] <= cell_value;
				cnt_q       <= last ? '0 : cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			win_s1 <= '{c0: window_q[0], c1: window_q[1], c2: window_q[2],
				c3: window_q[3], c4: cell_value};
		end
	end

endmodule

// ===== rtl/ppmr_face.sv =====
// ----------------------------------------------------------------------------
// ppmr_face
// Limited slopes and raw face values in 1/12 LSB units (stage 2).
// ----------------------------------------------------------------------------
module ppmr_face (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            slope_corr,
	input  ppmr_pkg::win_t  win_s1,
	input  ppmr_pkg::tag_t  tag_s1,
	output ppmr_pkg::face_t lf_s2,
	output ppmr_pkg::face_t rf_s2,
	output ppmr_pkg::face_t ctr_s2,
	output ppmr_pkg::tag_t  tag_s2
);
	import ppmr_pkg::*;

	diff_t  d10;
	diff_t  d21;
	diff_t  d32;
	diff_t  d43;
	slope_t s1;
	slope_t s2;
	slope_t s3;
	face_t  lf;
	face_t  rf;
	face_t  ctr;

	always_comb begin
		d10 = DIFF_W'(win_s1.c1) - DIFF_W'(win_s1.c0);
		d21 = DIFF_W'(win_s1.c2) - DIFF_W'(win_s1.c1);
		d32 = DIFF_W'(win_s1.c3) - DIFF_W'(win_s1.c2);
		d43 = DIFF_W'(win_s1.c4) - DIFF_W'(win_s1.c3);
		s1  = slope2(d21, d10);
		s2  = slope2(d32, d21);
		s3  = slope2(d43, d32);
		ctr = FACE_W'(win_s1.c2) * 40'sd12;
		lf  = (FACE_W'(win_s1.c1) + FACE_W'(win_s1.c2)) * 40'sd6;
		rf  = (FACE_W'(win_s1.c2) + FACE_W'(win_s1.c3)) * 40'sd6;
		if (slope_corr) begin
			lf = lf + FACE_W'(s1) - FACE_W'(s2);
			rf = rf + FACE_W'(s2) - FACE_W'(s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (en) begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lf_s2  <= lf;
			rf_s2  <= rf;
			ctr_s2 <= ctr;
		end
	end

endmodule

// ===== rtl/ppmr_limit.sv =====
// ----------------------------------------------------------------------------
// ppmr_limit
// PPM monotonicity limiter: flatten extrema, steepen overshoots (stage 3).
// ----------------------------------------------------------------------------
module ppmr_limit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            mono_lim,
	input  ppmr_pkg::face_t lf_s2,
	input  ppmr_pkg::face_t rf_s2,
	input  ppmr_pkg::face_t ctr_s2,
	input  ppmr_pkg::tag_t  tag_s2,
	output ppmr_pkg::face_t lf_s3,
	output ppmr_pkg::face_t rf_s3,
	output ppmr_pkg::tag_t  tag_s3
);
	import ppmr_pkg::*;

	wide_t lw;
	wide_t rw;
	wide_t qw;
	wide_t d;
	wide_t x;
	wide_t lo;
	wide_t ro;
	logic  mono;

	always_comb begin
		lw   = WIDE_W'(lf_s2);
		rw   = WIDE_W'(rf_s2);
		qw   = WIDE_W'(ctr_s2);
		d    = rw - lw;
		// 6 * (center - mean of faces), all in 1/12 LSB units
		x    = qw * 44'sd6 - (rw + lw) * 44'sd3;
		mono = (rw > qw && qw > lw) || (rw < qw && qw < lw);
		lo   = lw;
		ro   = rw;
		if (mono_lim) begin
			if (!mono) begin
				lo = qw;
				ro = qw;
			end else if ((d > 0 && x > d) || (d < 0 && x < d)) begin
				lo = qw * 44'sd3 - rw * 44'sd2;
			end else if ((d > 0 && x < -d) || (d < 0 && x > -d)) begin
				ro = qw * 44'sd3 - lw * 44'sd2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else if (en) begin
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lf_s3 <= FACE_W'(lo);
			rf_s3 <= FACE_W'(ro);
		end
	end

endmodule

// ===== rtl/ppmr_round.sv =====
// ----------------------------------------------------------------------------
// ppmr_round
// Divide by 12 with round-half-up and saturation to Q16.16 (stages 4, 5, out).
// ----------------------------------------------------------------------------
module ppmr_round (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  ppmr_pkg::face_t lf_s3,
	input  ppmr_pkg::face_t rf_s3,
	input  ppmr_pkg::tag_t  tag_s3,
	output ppmr_pkg::val_t  left_q,
	output ppmr_pkg::val_t  right_q,
	output ppmr_pkg::tag_t  tag_q
);
	import ppmr_pkg::*;

	localparam wide_t T_MAX = 44'sd25769803775;   // 12 * 2^31 - 1
	localparam wide_t T_MIN = -44'sd25769803776;  // -12 * 2^31
	localparam wide_t BIAS  = 44'sd6442450944;    // 3 * 2^31

	face_t       f_s3 [2];
	ubias_t      u_s4 [2];
	logic [15:0] qa_s5 [2];
	logic [17:0] x_s5 [2];
	val_t        res_q [2];
	ubias_t      u_d [2];
	div3_t       hi_d [2];
	div3_t       lo_d [2];
	wide_t       t [2];
	tag_t        tag_s4;
	tag_t        tag_s5;

	assign f_s3[0] = lf_s3;
	assign f_s3[1] = rf_s3;

	// clamp before the divide so the quotient lands in range; bias makes it unsigned
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			t[k] = WIDE_W'(f_s3[k]) + 44'sd6;
			if (t[k] > T_MAX)
				t[k] = T_MAX;
			else if (t[k] < T_MIN)
				t[k] = T_MIN;
			u_d[k]  = UBIAS_W'((t[k] >>> 2) + BIAS);
			hi_d[k] = div3(u_s4[k][UBIAS_W-1:16]);
			lo_d[k] = div3(x_s5[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (en) begin
			tag_q <= tag_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else if (en) begin
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++) begin
				u_s4[k]  <= u_d[k];
				qa_s5[k] <= hi_d[k].q;
				x_s5[k]  <= {hi_d[k].r, u_s4[k][15:0]};
				// quotient of the biased value carries +2^31: flip the sign bit
				res_q[k] <= {~qa_s5[k][15], qa_s5[k][14:0], lo_d[k].q};
			end
		end
	end

	assign left_q  = res_q[0];
	assign right_q = res_q[1];

endmodule

// ===== rtl/ppm_face_reconstruction.sv =====
// ----------------------------------------------------------------------------
// ppm_face_reconstruction
// PPM left/right face reconstruction over a streamed row of Q16.16 cells.
// ----------------------------------------------------------------------------
// Cells of one row enter on "cells" (cell_value, row_end), one transaction per
// cell. Once five cells of a row are in, each new cell yields one transaction
// on "faces" holding cell_number and the left and right faces of the cell two
// places back. The first four cells of a row give nothing; a row also ends
// at cell ROW_CELLS-1 without row_end.
// Six register stages: input window, slope/face, limiter, two divide-by-12
// stages, output. Throughput: one cell per cycle while faces.ready does not
// hold the pipeline, every stage being a single registered step of
// fixed-point adds, compares and small constant multiplies.
// cfg_we/cfg_index/cfg_wdata write slope_correction_on (0) and
// monotone_limit_on (1); write them only with the pipeline empty.
// Reset clears the window, the row position and all stage valids, and sets
// both options on. When faces.ready is low with a result waiting, the whole
// pipeline holds and cells.ready drops in the same cycle.
// ----------------------------------------------------------------------------
module ppm_face_reconstruction #(
	parameter int ROW_CELLS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ppmr_cell_if.sink                       cells,
	ppmr_face_if.source                     faces,
	input  logic                            cfg_we,
	input  logic [ppmr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppmr_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
	import ppmr_pkg::*;

	cfg_t  cfg_q;
	logic  adv;
	logic  take;
	cnt_t  row_pos;
	win_t  win_s1;
	tag_t  tag_s1;
	tag_t  tag_s2;
	tag_t  tag_s3;
	tag_t  tag_q;
	face_t lf_s2;
	face_t rf_s2;
	face_t ctr_s2;
	face_t lf_s3;
	face_t rf_s3;
	val_t  left_q;
	val_t  right_q;

	assign adv         = !tag_q.valid || faces.ready;
	assign take        = cells.valid && adv;
	assign cells.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slope_corr <= 1'b1;
			cfg_q.mono_lim   <= 1'b1;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SLOPE_CORR: cfg_q.slope_corr <= cfg_wdata[0];
				REG_MONO_LIM:   cfg_q.mono_lim   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	ppmr_window #(
		.ROW_CELLS (ROW_CELLS)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.take       (take),
		.cell_value (cells.cell_value),
		.row_end    (cells.row_end),
		.win_s1     (win_s1),
		.tag_s1     (tag_s1),
		.row_pos    (row_pos)
	);

	ppmr_face u_face (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.slope_corr (cfg_q.slope_corr),
		.win_s1     (win_s1),
		.tag_s1     (tag_s1),
		.lf_s2      (lf_s2),
		.rf_s2      (rf_s2),
		.ctr_s2     (ctr_s2),
		.tag_s2     (tag_s2)
	);

	ppmr_limit u_limit (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.mono_lim (cfg_q.mono_lim),
		.lf_s2    (lf_s2),
		.rf_s2    (rf_s2),
		.ctr_s2   (ctr_s2),
		.tag_s2   (tag_s2),
		.lf_s3    (lf_s3),
		.rf_s3    (rf_s3),
		.tag_s3   (tag_s3)
	);

	ppmr_round u_round (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.lf_s3   (lf_s3),
		.rf_s3   (rf_s3),
		.tag_s3  (tag_s3),
		.left_q  (left_q),
		.right_q (right_q),
		.tag_q   (tag_q)
	);

	assign faces.valid       = tag_q.valid;
	assign faces.cell_number = tag_q.cell_number;
	assign faces.left_face   = left_q;
	assign faces.right_face  = right_q;

`ifndef SYNTHESIS
	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cells.row_end) |=> (row_pos == '0))
		else $error("row position not cleared after row end");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_pos <= CNT_W'(ROW_CELLS - 1))
		else $error("row position beyond row length");

	a_face_index: assert property (@(posedge clk) disable iff (!arst_n)
		faces.valid |-> (faces.cell_number >= CNT_W'(2)
			&& faces.cell_number <= CNT_W'(ROW_CELLS - 3)))
		else $error("result for a non-interior cell");
`endif

endmodule
